// ----- sv/lpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpc_pkg: shared types and constants for the page tag cache
// Request and response word layouts, cache size, action codes and controller
// states.
// ----------------------------------------------------------------------------
package lpc_pkg;

	localparam int CACHE_SLOTS   = 4;
	localparam int PAGE_BITS     = 16;
	localparam int ZOOM_TAG_BITS = 32;
	localparam int SLOT_BITS     = $clog2(CACHE_SLOTS);
	localparam int ACTION_BITS   = 2;

	localparam logic [ACTION_BITS-1:0] ACT_LOOKUP = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_FILL   = 2'd1;
	localparam logic [ACTION_BITS-1:0] ACT_ANY    = 2'd2;

	typedef struct packed {
		logic [ACTION_BITS-1:0]   action;
		logic [PAGE_BITS-1:0]     page;
		logic [ZOOM_TAG_BITS-1:0] zoom_tag;
		logic                     content_valid;
	} req_word_t;

	typedef struct packed {
		logic                 hit;
		logic [SLOT_BITS-1:0] slot;
		logic                 render_request;
		logic                 evicted;
		logic [PAGE_BITS-1:0] evicted_page;
	} rsp_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

// ----- sv/lpc_cell.sv -----
// ----------------------------------------------------------------------------
// lpc_cell: one cache entry of the tag chain
// Holds page, zoom tag, content bit and recency rank of one slot. Folds its
// own compare results into the search word from its left neighbor and
// registers it for the right neighbor every cycle; applies rank and entry updates.
// ----------------------------------------------------------------------------
module lpc_cell #(
	parameter int  IDX_BITS = 2,
	parameter int  CELL_IDX = 0,
	parameter type link_t   = logic,
	parameter type upd_t    = logic
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  lpc_pkg::req_word_t item,
	input  link_t             link_in,
	output link_t             link_out,
	input  upd_t              upd
);

	localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

	logic [lpc_pkg::PAGE_BITS-1:0]     page_q;
	logic [lpc_pkg::ZOOM_TAG_BITS-1:0] zoom_q;
	logic                              ok_q;
	logic [IDX_BITS-1:0]               rank_q;
	link_t                             link_q;
	link_t                             link_d;
	logic                              page_eq;
	logic                              exact;

	always_comb begin
		page_eq = valid && (page_q == item.page);
		exact   = page_eq && (zoom_q == item.zoom_tag);
		link_d  = link_in;
		// lowest exact match wins for lookups
		if (exact && !link_in.lo_hit) begin
			link_d.lo_hit  = 1'b1;
			link_d.lo_idx  = MY_IDX;
			link_d.lo_rank = rank_q;
		end
		// highest exact match wins for fills
		if (exact) begin
			link_d.hi_hit  = 1'b1;
			link_d.hi_idx  = MY_IDX;
			link_d.hi_rank = rank_q;
		end
		if (valid && (!link_in.old_hit || rank_q > link_in.old_rank)) begin
			link_d.old_hit  = 1'b1;
			link_d.old_idx  = MY_IDX;
			link_d.old_rank = rank_q;
			link_d.old_page = page_q;
		end
		if (page_eq && ok_q && (!link_in.any_hit || rank_q < link_in.any_rank)) begin
			link_d.any_hit  = 1'b1;
			link_d.any_idx  = MY_IDX;
			link_d.any_rank = rank_q;
		end
	end

	assign link_out = link_q;

	always_ff @(posedge clk) begin
		link_q <= link_d;
		if (upd.en && upd.write && upd.slot == MY_IDX) begin
			page_q <= upd.page;
			zoom_q <= upd.zoom;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q   <= 1'b0;
			rank_q <= '0;
		end else if (upd.en) begin
			if (upd.slot == MY_IDX) begin
				rank_q <= '0;
				if (upd.write) begin
					ok_q <= upd.ok;
				end
			end else if (valid && rank_q < upd.lim) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

endmodule

// ----- sv/lru_page_cache.sv -----
// ----------------------------------------------------------------------------
// lru_page_cache: fully associative page tag cache with LRU replacement
// Chain of entry cells searched by a word that walks one cell per cycle,
// followed by an update step that applies the hit, fill or eviction to all cells.
// ----------------------------------------------------------------------------
//  channel | handshake            | word | contents
//  --------+----------------------+------+---------------------------------
//  req     | req_valid/req_ready  | req  | action, page, zoom_tag, content
//  rsp     | rsp_valid/rsp_ready  | rsp  | hit, slot, request, eviction
//
// An item goes through accept, a scan step per cell while the search word walks
// the chain, and an update step that applies the result.
// Only one item is in flight; req_ready is high while the controller idles.
// The response sits in an output register; the next item is accepted while it
// waits. A stalled response holds the update cycle until the register frees.
// Reset clears content bits, ranks, fill count and controller state.
module lru_page_cache (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  lpc_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output lpc_pkg::rsp_word_t rsp
);

	localparam int CACHE_SLOTS = lpc_pkg::CACHE_SLOTS;
	localparam int IDX_BITS = lpc_pkg::SLOT_BITS;
	localparam int CNT_BITS = $clog2(CACHE_SLOTS + 1);
	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CACHE_SLOTS - 1);
	localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(CACHE_SLOTS);

	typedef struct packed {
		logic                          lo_hit;
		logic [IDX_BITS-1:0]           lo_idx;
		logic [IDX_BITS-1:0]           lo_rank;
		logic                          hi_hit;
		logic [IDX_BITS-1:0]           hi_idx;
		logic [IDX_BITS-1:0]           hi_rank;
		logic                          old_hit;
		logic [IDX_BITS-1:0]           old_idx;
		logic [IDX_BITS-1:0]           old_rank;
		logic [lpc_pkg::PAGE_BITS-1:0] old_page;
		logic                          any_hit;
		logic [IDX_BITS-1:0]           any_idx;
		logic [IDX_BITS-1:0]           any_rank;
	} link_t;

	typedef struct packed {
		logic                              en;
		logic                              write;
		logic [IDX_BITS-1:0]               slot;
		logic [IDX_BITS-1:0]               lim;
		logic [lpc_pkg::PAGE_BITS-1:0]     page;
		logic [lpc_pkg::ZOOM_TAG_BITS-1:0] zoom;
		logic                              ok;
	} upd_t;

	lpc_pkg::state_t     state_q, state_d;
	logic [IDX_BITS-1:0] scan_cnt_q;
	logic [CNT_BITS-1:0] fill_count_q;
	lpc_pkg::req_word_t  item_q;
	logic                rsp_valid_q;
	lpc_pkg::rsp_word_t  rsp_q, rsp_d;
	upd_t                upd;
	logic                finish_go;
	logic                bump_count;
	link_t               links [CACHE_SLOTS];
	link_t               last;
	logic [CACHE_SLOTS-1:0] cell_valid;

	for (genvar i = 0; i < CACHE_SLOTS; i++) begin : g_cell
		link_t link_in;
		assign cell_valid[i] = CNT_BITS'(i) < fill_count_q;
		if (i == 0) begin : g_head
			assign link_in = '0;
		end else begin : g_body
			assign link_in = links[i-1];
		end
		lpc_cell #(
			.IDX_BITS (IDX_BITS),
			.CELL_IDX (i),
			.link_t   (link_t),
			.upd_t    (upd_t)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid    (cell_valid[i]),
			.item     (item_q),
			.link_in  (link_in),
			.link_out (links[i]),
			.upd      (upd)
		);
	end

	assign last = links[CACHE_SLOTS-1];

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		finish_go  = 1'b0;
		bump_count = 1'b0;
		rsp_d      = '0;
		upd        = '0;
		upd.page   = item_q.page;
		upd.zoom   = item_q.zoom_tag;
		upd.ok     = item_q.content_valid;
		case (item_q.action)
			lpc_pkg::ACT_LOOKUP: begin
				if (last.lo_hit) begin
					rsp_d.hit  = 1'b1;
					rsp_d.slot = lpc_pkg::SLOT_BITS'(last.lo_idx);
					upd.en     = 1'b1;
					upd.slot   = last.lo_idx;
					upd.lim    = last.lo_rank;
				end else begin
					rsp_d.render_request = 1'b1;
				end
			end
			lpc_pkg::ACT_FILL: begin
				upd.en    = 1'b1;
				upd.write = 1'b1;
				if (last.hi_hit) begin
					rsp_d.hit = 1'b1;
					upd.slot  = last.hi_idx;
					upd.lim   = last.hi_rank;
				end else if (fill_count_q < FULL_CNT) begin
					// new entry: every filled entry ages by one
					upd.slot   = fill_count_q[IDX_BITS-1:0];
					upd.lim    = fill_count_q[IDX_BITS-1:0];
					bump_count = 1'b1;
				end else begin
					upd.slot           = last.old_idx;
					upd.lim            = last.old_rank;
					rsp_d.evicted      = 1'b1;
					rsp_d.evicted_page = last.old_page;
				end
				rsp_d.slot = lpc_pkg::SLOT_BITS'(upd.slot);
			end
			lpc_pkg::ACT_ANY: begin
				if (last.any_hit) begin
					rsp_d.hit  = 1'b1;
					rsp_d.slot = lpc_pkg::SLOT_BITS'(last.any_idx);
				end
			end
			default: begin
			end
		endcase

		case (state_q)
			lpc_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = lpc_pkg::ST_SCAN;
				end
			end
			lpc_pkg::ST_SCAN: begin
				if (scan_cnt_q == LAST_IDX) begin
					state_d = lpc_pkg::ST_FINISH;
				end
			end
			lpc_pkg::ST_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					finish_go = 1'b1;
					state_d   = lpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpc_pkg::ST_IDLE;
			end
		endcase

		if (!finish_go) begin
			upd.en     = 1'b0;
			bump_count = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lpc_pkg::ST_IDLE;
			scan_cnt_q   <= '0;
			fill_count_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lpc_pkg::ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end else begin
				scan_cnt_q <= '0;
			end
			if (bump_count) begin
				fill_count_q <= fill_count_q + 1'b1;
			end
			if (finish_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req;
		end
		if (finish_go) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// fill count never runs past the number of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= FULL_CNT)
		else $error("fill count beyond cache size");

	// eviction only happens with every slot filled
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go && rsp_d.evicted |-> fill_count_q == FULL_CNT)
		else $error("eviction with free slot");

	// a render request is never paired with a hit
	a_req_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.render_request && rsp.hit))
		else $error("render request on hit");

	// update cycle always produces a response word
	a_finish_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go |=> rsp_valid)
		else $error("update without response");

endmodule
